/* hdl/owsse_pkg.sv */
// ----------------------------------------------------------------------------
// owsse_pkg
// shared types, command codes and crc helpers for the one-wire sensor endpoint
// ----------------------------------------------------------------------------
package owsse_pkg;

   localparam int ID_W           = 56;
   localparam int DATA_BYTES_DEF = 2;
   localparam int ID_BYTES       = 7;

   localparam logic [ID_W-1:0] DEVICE_ID_RESET = 56'h07_0000_0000_00F3;

   // rom and function commands
   localparam logic [7:0] CMD_SEARCH = 8'hF0;
   localparam logic [7:0] CMD_ALARM  = 8'hEC;
   localparam logic [7:0] CMD_MATCH  = 8'h55;
   localparam logic [7:0] CMD_READ   = 8'hA0;

   // reflected x^8+x^5+x^4+1
   localparam logic [7:0] CRC_POLY = 8'h8C;

   // item kinds carried in tuser
   localparam logic [1:0] MODE_RESET  = 2'd0;
   localparam logic [1:0] MODE_SLOT   = 2'd1;
   localparam logic [1:0] MODE_SENSOR = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_ROM    = 3'd1,
      PH_SEARCH = 3'd2,
      PH_MATCH  = 3'd3,
      PH_FUNC   = 3'd4,
      PH_SEND   = 3'd5
   } phase_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       bus_level;
      logic [7:0] humidity;
      logic [7:0] temperature;
      logic [7:0] checksum;
   } item_type;

   // pull_low_next in bit 0
   typedef struct packed {
      logic      changed;
      phase_type phase;
      logic      presence;
      logic      pull_low_next;
   } result_type;

   typedef struct packed {
      logic       busy;
      logic [7:0] check_byte;
   } crc_status_type;

   function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic b);
      logic [7:0] c;
      c = {1'b0, crc[7:1]};
      if (crc[0] ^ b) begin
         c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         c = crc_bit(c, d[i]);
      end
      return c;
   endfunction

endpackage

/* hdl/owsse_idcrc.sv */
// ----------------------------------------------------------------------------
// owsse_idcrc
// holds the device id and works out its crc check byte, one id byte a cycle
// ----------------------------------------------------------------------------
module owsse_idcrc (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_valid,
   input  logic [owsse_pkg::ID_W-1:0]  wr_data,
   output logic [owsse_pkg::ID_W-1:0]  device_id,
   output owsse_pkg::crc_status_type   status
);
   import owsse_pkg::*;

   localparam int CW = $clog2(ID_BYTES);

   logic [ID_W-1:0] id_ff;
   logic [7:0]      crc_ff,  crc_in;
   logic [7:0]      check_ff;
   logic [CW-1:0]   cnt_ff;
   logic            busy_ff;

   assign crc_in = crc_byte(crc_ff, id_ff[{cnt_ff, 3'b000} +: 8]);

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff   <= DEVICE_ID_RESET;
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         crc_ff  <= '0;
      end else if (wr_valid) begin
         id_ff   <= wr_data;
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         crc_ff  <= '0;
      end else if (busy_ff) begin
         crc_ff <= crc_in;
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CW'(ID_BYTES - 1)) begin
            busy_ff  <= 1'b0;
            check_ff <= crc_in;
         end
      end
   end

   assign device_id         = id_ff;
   assign status.busy       = busy_ff;
   assign status.check_byte = check_ff;

endmodule

/* hdl/owsse_core.sv */
// ----------------------------------------------------------------------------
// owsse_core
// protocol state machine and sensor store, one item per step
// ----------------------------------------------------------------------------
module owsse_core #(
   parameter int DATA_BYTES = owsse_pkg::DATA_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  owsse_pkg::item_type         item,
   input  logic [owsse_pkg::ID_W-1:0]  device_id,
   input  logic [7:0]                  check_byte,
   output owsse_pkg::result_type       result
);
   import owsse_pkg::*;

   // byte counter must reach DATA_BYTES and index all eight id bytes
   localparam int BPW = ($clog2(DATA_BYTES + 2) > 3) ? $clog2(DATA_BYTES + 2) : 3;

   phase_type      phase_ff,   phase_in;
   logic [7:0]     shift_ff,   shift_in;
   logic [5:0]     bitpos_ff,  bitpos_in;
   logic [1:0]     sub_ff,     sub_in;
   logic [BPW-1:0] bytepos_ff, bytepos_in;
   logic [7:0]     crc_ff,     crc_in;
   logic [7:0]     hum_ff,     hum_in;
   logic [7:0]     tmp_ff,     tmp_in;
   logic           change_ff,  change_in;

   logic [63:0]    idv;
   logic [7:0]     rx_byte;
   logic [5:0]     rx_pos;
   logic           rx_full;
   logic [8:0]     sensor_sum;
   logic           send_b;
   logic           presence;
   logic           pull;

   function automatic logic send_bit(input logic [BPW-1:0] bp, input logic [2:0] bit_i,
                                     input logic [7:0] crc, input logic [7:0] h,
                                     input logic [7:0] t);
      logic [7:0] b;
      if (bp < BPW'(DATA_BYTES)) begin
         if (bp == BPW'(0)) begin
            b = h;
         end else if (bp == BPW'(1)) begin
            b = t;
         end else begin
            b = 8'h00;
         end
      end else begin
         b = crc;
      end
      return b[bit_i];
   endfunction

   assign idv        = {check_byte, device_id};
   assign rx_byte    = {item.bus_level, shift_ff[7:1]};
   assign rx_pos     = bitpos_ff + 6'd1;
   assign rx_full    = (rx_pos[5:3] != 3'd0);
   assign sensor_sum = {1'b0, item.humidity} + {1'b0, item.temperature};
   assign send_b     = send_bit(bytepos_ff, bitpos_ff[2:0], crc_ff, hum_ff, tmp_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         shift_ff   <= '0;
         bitpos_ff  <= '0;
         sub_ff     <= '0;
         bytepos_ff <= '0;
         crc_ff     <= '0;
         hum_ff     <= '0;
         tmp_ff     <= '0;
         change_ff  <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         shift_ff   <= shift_in;
         bitpos_ff  <= bitpos_in;
         sub_ff     <= sub_in;
         bytepos_ff <= bytepos_in;
         crc_ff     <= crc_in;
         hum_ff     <= hum_in;
         tmp_ff     <= tmp_in;
         change_ff  <= change_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      shift_in   = shift_ff;
      bitpos_in  = bitpos_ff;
      sub_in     = sub_ff;
      bytepos_in = bytepos_ff;
      crc_in     = crc_ff;
      hum_in     = hum_ff;
      tmp_in     = tmp_ff;
      change_in  = change_ff;
      presence   = 1'b0;

      unique case (item.mode)
         MODE_RESET: begin
            presence   = 1'b1;
            phase_in   = PH_ROM;
            shift_in   = '0;
            bitpos_in  = '0;
            bytepos_in = '0;
            sub_in     = '0;
         end
         MODE_SLOT: begin
            unique case (phase_ff)
               PH_ROM: begin
                  shift_in  = rx_byte;
                  bitpos_in = rx_pos;
                  if (rx_full) begin
                     bitpos_in  = '0;
                     bytepos_in = '0;
                     sub_in     = '0;
                     shift_in   = '0;
                     if (rx_byte == CMD_SEARCH || (rx_byte == CMD_ALARM && change_ff)) begin
                        phase_in = PH_SEARCH;
                     end else if (rx_byte == CMD_MATCH) begin
                        phase_in = PH_MATCH;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
               end
               PH_SEARCH: begin
                  if (sub_ff < 2'd2) begin
                     sub_in = sub_ff + 2'd1;
                  end else begin
                     sub_in = '0;
                     if (item.bus_level != idv[bitpos_ff]) begin
                        phase_in = PH_IDLE;
                     end else if (bitpos_ff == 6'd63) begin
                        phase_in = PH_IDLE;
                     end else begin
                        bitpos_in = rx_pos;
                     end
                  end
               end
               PH_MATCH: begin
                  shift_in  = rx_byte;
                  bitpos_in = rx_pos;
                  if (rx_full) begin
                     bitpos_in = '0;
                     shift_in  = '0;
                     if (rx_byte != idv[{bytepos_ff[2:0], 3'b000} +: 8]) begin
                        phase_in = PH_IDLE;
                     end else if (bytepos_ff >= BPW'(7)) begin
                        bytepos_in = '0;
                        phase_in   = PH_FUNC;
                     end else begin
                        bytepos_in = bytepos_ff + 1'b1;
                     end
                  end
               end
               PH_FUNC: begin
                  shift_in  = rx_byte;
                  bitpos_in = rx_pos;
                  if (rx_full) begin
                     bitpos_in  = '0;
                     bytepos_in = '0;
                     shift_in   = '0;
                     if (rx_byte == CMD_READ) begin
                        change_in = 1'b0;
                        crc_in    = '0;
                        phase_in  = PH_SEND;
                     end else begin
                        phase_in = PH_IDLE;
                     end
                  end
               end
               PH_SEND: begin
                  if (bytepos_ff < BPW'(DATA_BYTES)) begin
                     crc_in = crc_bit(crc_ff, send_b);
                  end
                  bitpos_in = rx_pos;
                  if (rx_full) begin
                     bitpos_in  = '0;
                     bytepos_in = bytepos_ff + 1'b1;
                     if (bytepos_ff >= BPW'(DATA_BYTES)) begin
                        bytepos_in = '0;
                        phase_in   = PH_IDLE;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         MODE_SENSOR: begin
            // unwrapped sum must match a nonzero checksum and differ from the store
            if (sensor_sum == {1'b0, item.checksum} && item.checksum != 8'h00 &&
                (item.humidity != hum_ff || item.temperature != tmp_ff)) begin
               hum_in    = item.humidity;
               tmp_in    = item.temperature;
               change_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // drive level for the slot after this item, from the updated state
   always_comb begin
      pull = 1'b0;
      unique case (phase_in)
         PH_SEARCH: begin
            if (sub_in == 2'd0) begin
               pull = ~idv[bitpos_in];
            end else if (sub_in == 2'd1) begin
               pull = idv[bitpos_in];
            end
         end
         PH_SEND: begin
            pull = ~send_bit(bytepos_in, bitpos_in[2:0], crc_in, hum_in, tmp_in);
         end
         default: begin
         end
      endcase
   end

   assign result.pull_low_next = pull;
   assign result.presence      = presence;
   assign result.phase         = phase_in;
   assign result.changed       = change_in;

endmodule

/* hdl/one_wire_slave_sensor_endpoint.sv */
// ----------------------------------------------------------------------------
// one_wire_slave_sensor_endpoint
// 1-wire slave at bit-slot level with rom search/match and a sensor data store
// an accepted item is held in the input register, then its result in the result register
// throughput: one item per cycle while rsp does not stall and no check byte pass runs; the result
// register can hold while a new item is taken. reset: synchronous; afterwards the id check
// byte is worked out, items held off, and a device_id write restarts the check byte pass
// ----------------------------------------------------------------------------
module one_wire_slave_sensor_endpoint #(
   parameter int DATA_BYTES = owsse_pkg::DATA_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [0] bus_level, [8:1] humidity, [16:9] temperature, [24:17] checksum
   input  logic [31:0]                 req_tdata,
   // [1:0] mode
   input  logic [1:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [0] pull_low_next, [1] presence, [4:2] phase, [5] changed
   output logic [7:0]                  rsp_tdata,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [owsse_pkg::ID_W-1:0]  csr_data
);
   import owsse_pkg::*;

   logic                in_valid_ff;
   item_type            in_ff;
   logic                out_valid_ff;
   result_type          out_ff;
   result_type          core_result;
   logic                advance;
   logic                accept;
   logic [ID_W-1:0]     device_id;
   crc_status_type      crc_status;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !crc_status.busy && (!in_valid_ff || advance);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff.mode        <= req_tuser;
         in_ff.bus_level   <= req_tdata[0];
         in_ff.humidity    <= req_tdata[8:1];
         in_ff.temperature <= req_tdata[16:9];
         in_ff.checksum    <= req_tdata[24:17];
      end
      if (advance) begin
         out_ff <= core_result;
      end
   end

   owsse_idcrc u_idcrc (
      .clock     (clock),
      .reset     (reset),
      .wr_valid  (csr_valid),
      .wr_data   (csr_data),
      .device_id (device_id),
      .status    (crc_status)
   );

   owsse_core #(
      .DATA_BYTES (DATA_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (in_ff),
      .device_id  (device_id),
      .check_byte (crc_status.check_byte),
      .result     (core_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff};

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the one-wire sensor endpoint: a slot-level model of
// the slave predicts every reply while random rom search, match and read
// sequences, sensor frames and bus noise run under several device ids
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import owsse_pkg::*;

   localparam int DATA_BYTES     = DATA_BYTES_DEF;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int STALL_CYCLES   = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int PHASE_ITEMS    = 30;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [31:0]         req_tdata  = '0;
   logic [1:0]          req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [7:0]          rsp_tdata;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [ID_W-1:0]     csr_data   = '0;

   one_wire_slave_sensor_endpoint #(
      .DATA_BYTES(DATA_BYTES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // slave model state
   // ------------------------------------------------------------------
   logic [ID_W-1:0] dev_id      = DEVICE_ID_RESET;
   logic [7:0]      dev_check   = '0;
   phase_type       ph          = PH_IDLE;
   logic [7:0]      rx_shift    = '0;
   logic [5:0]      bit_idx     = '0;
   logic [1:0]      sub_step    = '0;
   logic [2:0]      byte_idx    = '0;
   logic [7:0]      data_crc    = '0;
   logic [7:0]      hum_store   = '0;
   logic [7:0]      temp_store  = '0;
   logic            change_flag = 1'b0;

   item_type        bus_items_to_send[$];
   result_type      bus_replies_due[$];
   item_type        sent_item;
   int              queued_count  = 0;
   int              fail_count    = 0;
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_idle_pct = 0;
   int unsigned     stall_order   = 0;
   int unsigned     stall_seen    = 0;
   int unsigned     stall_left    = 0;
   int unsigned     quiet_cycles  = 0;

   function automatic logic [7:0] crc8_shift(logic [7:0] crc, logic b);
      logic fb;
      fb  = crc[0] ^ b;
      crc = crc >> 1;
      if (fb) begin
         crc = crc ^ CRC_POLY;
      end
      return crc;
   endfunction

   function automatic logic [7:0] id_check(logic [ID_W-1:0] id);
      logic [7:0] crc;
      crc = '0;
      for (int n = 0; n < ID_W; n++) begin
         crc = crc8_shift(crc, id[n]);
      end
      return crc;
   endfunction

   function automatic logic [7:0] id_octet(int n);
      if (n == 7) begin
         return dev_check;
      end
      return dev_id[8*n +: 8];
   endfunction

   function automatic logic id_bit_at(logic [5:0] n);
      logic [7:0] octet;
      octet = id_octet(int'(n[5:3]));
      return octet[n[2:0]];
   endfunction

   function automatic logic [7:0] data_octet(int n);
      if (n < DATA_BYTES) begin
         if (n == 0) return hum_store;
         if (n == 1) return temp_store;
         return '0;
      end
      return data_crc;
   endfunction

   function automatic logic send_bit_now();
      logic [7:0] octet;
      octet = data_octet(int'(byte_idx));
      return octet[bit_idx[2:0]];
   endfunction

   // whether the slave pulls the bus low in the coming slot, high means it pulls
   function automatic logic pull_after();
      logic wb;
      case (ph)
         PH_SEARCH: begin
            wb = id_bit_at(bit_idx);
            if (sub_step == 2'd0) return !wb;
            if (sub_step == 2'd1) return wb;
            return 1'b0;
         end
         PH_SEND: begin
            return !send_bit_now();
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   task automatic take_bit(input logic lvl);
      rx_shift = {lvl, rx_shift[7:1]};
      bit_idx  = bit_idx + 1'b1;
   endtask

   task automatic bus_slot(input logic lvl);
      logic b;
      case (ph)
         PH_ROM: begin
            take_bit(lvl);
            if (bit_idx == 6'd8) begin
               bit_idx  = '0;
               byte_idx = '0;
               sub_step = '0;
               if (rx_shift == CMD_SEARCH || (rx_shift == CMD_ALARM && change_flag)) begin
                  ph = PH_SEARCH;
               end else if (rx_shift == CMD_MATCH) begin
                  ph = PH_MATCH;
               end else begin
                  ph = PH_IDLE;
               end
               rx_shift = '0;
            end
         end
         PH_SEARCH: begin
            if (sub_step < 2'd2) begin
               sub_step = sub_step + 1'b1;
            end else begin
               sub_step = '0;
               if (lvl != id_bit_at(bit_idx)) begin
                  ph = PH_IDLE;
               end else if (bit_idx == 6'd63) begin
                  ph = PH_IDLE;
               end else begin
                  bit_idx = bit_idx + 1'b1;
               end
            end
         end
         PH_MATCH: begin
            take_bit(lvl);
            if (bit_idx == 6'd8) begin
               bit_idx = '0;
               if (rx_shift != id_octet(int'(byte_idx))) begin
                  ph = PH_IDLE;
               end else if (byte_idx == 3'd7) begin
                  byte_idx = '0;
                  ph       = PH_FUNC;
               end else begin
                  byte_idx = byte_idx + 1'b1;
               end
               rx_shift = '0;
            end
         end
         PH_FUNC: begin
            take_bit(lvl);
            if (bit_idx == 6'd8) begin
               bit_idx  = '0;
               byte_idx = '0;
               if (rx_shift == CMD_READ) begin
                  change_flag = 1'b0;
                  data_crc    = '0;
                  ph          = PH_SEND;
               end else begin
                  ph = PH_IDLE;
               end
               rx_shift = '0;
            end
         end
         PH_SEND: begin
            b = send_bit_now();
            if (byte_idx < DATA_BYTES) begin
               data_crc = crc8_shift(data_crc, b);
            end
            bit_idx = bit_idx + 1'b1;
            if (bit_idx >= 6'd8) begin
               bit_idx  = '0;
               byte_idx = byte_idx + 1'b1;
               if (byte_idx > DATA_BYTES) begin
                  byte_idx = '0;
                  ph       = PH_IDLE;
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic advance_slave_state(input item_type it, output result_type r);
      logic [8:0] sum;
      r.presence = 1'b0;
      case (it.mode)
         MODE_RESET: begin
            r.presence = 1'b1;
            ph         = PH_ROM;
            rx_shift   = '0;
            bit_idx    = '0;
            byte_idx   = '0;
            sub_step   = '0;
         end
         MODE_SLOT: begin
            bus_slot(it.bus_level);
         end
         MODE_SENSOR: begin
            // the sum must match without wrapping
            sum = {1'b0, it.humidity} + {1'b0, it.temperature};
            if (sum == {1'b0, it.checksum} && it.checksum != 8'd0 &&
                (it.humidity != hum_store || it.temperature != temp_store)) begin
               hum_store   = it.humidity;
               temp_store  = it.temperature;
               change_flag = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.pull_low_next = pull_after();
      r.phase         = ph;
      r.changed       = change_flag;
   endtask

   task automatic check_field(input string name, input logic [2:0] want,
                              input logic [2:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // ------------------------------------------------------------------
   // driver, receiver, monitor, watchdog
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (bus_items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            it = bus_items_to_send.pop_front();
            sent_item  <= it;
            req_tvalid <= 1'b1;
            req_tdata  <= {7'd0, it.checksum, it.temperature, it.humidity, it.bus_level};
            req_tuser  <= it.mode;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_seen != stall_order) begin
         stall_seen <= stall_order;
         stall_left <= STALL_CYCLES;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[5:0]);
            if (bus_replies_due.size() == 0) begin
               $error("rsp item 0x%h arrived with nothing pending", rsp_tdata);
               fail_count++;
            end else begin
               want = bus_replies_due.pop_front();
               check_field("pull_low_next", want.pull_low_next, got.pull_low_next);
               check_field("presence", want.presence, got.presence);
               check_field("phase", want.phase, got.phase);
               check_field("changed", want.changed, got.changed);
            end
         end
         if (req_tvalid && req_tready) begin
            advance_slave_state(sent_item, want);
            bus_replies_due.push_back(want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   task automatic push_item(input logic [1:0] mode, input logic lvl, input logic [7:0] h,
                            input logic [7:0] t, input logic [7:0] c);
      item_type it;
      it.mode        = mode;
      it.bus_level   = lvl;
      it.humidity    = h;
      it.temperature = t;
      it.checksum    = c;
      bus_items_to_send.push_back(it);
      queued_count++;
   endtask

   task automatic push_slot(input logic lvl);
      push_item(MODE_SLOT, lvl, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic push_reset();
      push_item(MODE_RESET, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // master writes a byte lsb first
   task automatic push_byte(input logic [7:0] b);
      for (int i = 0; i < 8; i++) begin
         push_slot(b[i]);
      end
   endtask

   task automatic push_good_sensor();
      int h;
      int t;
      h = $urandom_range(255);
      t = $urandom_range(255 - h);
      if (h + t == 0) begin
         h = 1;
      end
      push_item(MODE_SENSOR, 1'($urandom), 8'(h), 8'(t), 8'(h + t));
   endtask

   task automatic push_any_sensor();
      if ($urandom_range(2) == 0) begin
         push_good_sensor();
      end else begin
         push_item(MODE_SENSOR, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic gen_search(input logic [7:0] cmd, input bit may_miss);
      int   miss_at;
      logic choice;
      miss_at = (may_miss && $urandom_range(1) == 1) ? $urandom_range(63) : 64;
      push_reset();
      push_byte(cmd);
      for (int n = 0; n < 64; n++) begin
         push_slot(1'($urandom));
         push_slot(1'($urandom));
         choice = id_bit_at(6'(n));
         if (n == miss_at) begin
            push_slot(!choice);
            break;
         end
         push_slot(choice);
      end
   endtask

   task automatic gen_match_read();
      int         bad;
      logic [7:0] b;
      bad = ($urandom_range(5) == 0) ? $urandom_range(63) : 64;
      push_reset();
      push_byte(CMD_MATCH);
      for (int n = 0; n < 8; n++) begin
         b = id_octet(n);
         if (bad / 8 == n) begin
            b[bad % 8] = !b[bad % 8];
         end
         push_byte(b);
      end
      push_byte(($urandom_range(4) == 0) ? 8'($urandom) : CMD_READ);
      // two data bytes and the crc, sometimes a few extra slots
      repeat (8 * (DATA_BYTES + 1) + $urandom_range(3)) begin
         push_slot(1'($urandom));
      end
   endtask

   task automatic gen_noise();
      if ($urandom_range(1) == 0) begin
         push_reset();
         push_byte(8'($urandom));
      end else begin
         repeat (1 + $urandom_range(3)) begin
            push_item(2'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom));
         end
      end
   endtask

   task automatic run_random(input int target);
      int start;
      start = queued_count;
      while (queued_count - start < target) begin
         case ($urandom_range(19))
            0, 1, 2, 3, 4: begin
               gen_search(CMD_SEARCH, 1'b1);
            end
            5, 6: begin
               push_good_sensor();
               gen_search(CMD_ALARM, 1'b1);
            end
            7, 8, 9, 10, 11, 12, 13: begin
               gen_match_read();
            end
            14, 15, 16: begin
               repeat (1 + $urandom_range(2)) push_any_sensor();
            end
            default: begin
               gen_noise();
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      while (bus_items_to_send.size() != 0 || req_tvalid || bus_replies_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_device_id(input logic [ID_W-1:0] value);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      dev_id    = value;
      dev_check = id_check(value);
      @(negedge clock);
   endtask

   initial begin
      dev_check = id_check(dev_id);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // short directed run on the reset id
      push_slot(1'b1);                                   // slot while idle
      push_item(MODE_UNUSED, 1'b1, 8'hFF, 8'hFF, 8'hFF);
      push_reset();
      push_byte(CMD_ALARM);                              // alarm search, flag clear
      push_item(MODE_SENSOR, 1'b0, 8'h00, 8'h00, 8'h00); // zero checksum
      push_item(MODE_SENSOR, 1'b0, 8'hFF, 8'hFF, 8'hFE); // sum must not wrap
      push_item(MODE_SENSOR, 1'b1, 8'hFF, 8'h00, 8'hFF);
      push_item(MODE_SENSOR, 1'b0, 8'hFF, 8'h00, 8'hFF); // same values again
      push_reset();
      push_slot(1'b1);
      push_slot(1'b0);
      push_slot(1'b1);
      push_reset();                                      // reset mid command
      push_byte(8'h3C);                                  // unknown rom command
      wait_drained();

      write_device_id({ID_W{1'b1}});
      send_idle_pct = 10;
      recv_idle_pct = 54;
      gen_search(CMD_SEARCH, 1'b0);
      run_random(PHASE_ITEMS);
      wait_drained();

      write_device_id('0);
      send_idle_pct = 54;
      recv_idle_pct = 10;
      run_random(PHASE_ITEMS);
      wait_drained();

      write_device_id(ID_W'({$urandom, $urandom}));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(PHASE_ITEMS);
      // hold rsp off while req keeps offering so the block backs up
      stall_order++;
      wait_drained();

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/owsse_pkg.sv
hdl/owsse_idcrc.sv
hdl/owsse_core.sv
hdl/one_wire_slave_sensor_endpoint.sv
bench/testbench.sv
